FILE: design/median_peak_hold_velocity_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the median peak-hold velocity filter
// Concurrent checks clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_PEAK_HOLD_VELOCITY_FILTER_CORE_MACROS_SVH
`define MEDIAN_PEAK_HOLD_VELOCITY_FILTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle property
`define MPHVF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next
`define MPHVF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`else

`define MPHVF_ASSERT(lbl, prop, msg)
`define MPHVF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/mphvf_pkg.sv
// ----------------------------------------------------------------------------
// mphvf_pkg
// Types, constants and helper functions shared by the velocity filter.
// ----------------------------------------------------------------------------
package mphvf_pkg;

	// Geometry
	localparam int WINDOW_LEN  = 9;
	localparam int FRAC_BITS   = 8;
	localparam int VAL_W       = 26;
	localparam int BAND_W      = 20;
	localparam int HOLD_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int WIDE_W      = VAL_W + 2;
	localparam int IDX_W       = $clog2(WINDOW_LEN);
	localparam int CNT_W       = $clog2(WINDOW_LEN + 1);
	localparam int MEDIAN_RANK = WINDOW_LEN / 2;

	typedef logic signed [VAL_W-1:0]  sample_t;
	typedef logic        [VAL_W-1:0]  mag_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic        [BAND_W-1:0] band_t;

	// Floors: 100000 whole units, saturated to the sample range
	localparam longint FLOOR_RAW = longint'(100000) << FRAC_BITS;
	localparam longint VAL_MAX   = (longint'(1) << (VAL_W - 1)) - 1;
	localparam longint FLOOR_LIM = (FLOOR_RAW > VAL_MAX) ? VAL_MAX : FLOOR_RAW;
	localparam sample_t POS_FLOOR_RST = sample_t'(FLOOR_LIM);
	localparam sample_t NEG_FLOOR_RST = sample_t'(-FLOOR_LIM);

	// Register reset values in whole units scaled to the fraction
	localparam band_t SLOPE_BAND_RST  = band_t'(10 << FRAC_BITS);
	localparam band_t SPEED_DB_RST    = band_t'(2 << FRAC_BITS);
	localparam band_t ACCEL_DB_RST    = band_t'(2 << FRAC_BITS);
	localparam band_t BRAKE_JUMP_RST  = band_t'(10 << FRAC_BITS);
	localparam band_t SPEED_LIMIT_RST = band_t'(120 << FRAC_BITS);
	localparam logic [HOLD_W-1:0] HOLD_PERIOD_RST = HOLD_W'(4);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_BAND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_DB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DB    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_JUMP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIOD = 3'd5;

	// Absolute value; the most negative sample maps to 2^(VAL_W-1)
	function automatic mag_t magnitude(input sample_t v);
		return v[VAL_W-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	// a orders before b: larger magnitude, positive first on a tie
	function automatic logic ranks_before(input sample_t a, input sample_t b);
		mag_t ma;
		mag_t mb;
		ma = magnitude(a);
		mb = magnitude(b);
		if (ma != mb)
			return ma > mb;
		return a > b;
	endfunction

	// Truncate toward zero to a whole unit
	function automatic sample_t trunc_whole(input sample_t v);
		mag_t t;
		t = magnitude(v) & ~mag_t'((1 << FRAC_BITS) - 1);
		return v[VAL_W-1] ? sample_t'(-t) : sample_t'(t);
	endfunction

	// Sign extension of a sample to the difference width
	function automatic wide_t widen(input sample_t v);
		return wide_t'(v);
	endfunction

	// Zero extension of a band register to the difference width
	function automatic wide_t band_wide(input band_t b);
		return $signed({{(WIDE_W - BAND_W){1'b0}}, b});
	endfunction

endpackage

FILE: design/median_peak_hold_velocity_filter_core.sv
// ----------------------------------------------------------------------------
// median_peak_hold_velocity_filter_core
// Median window filter with peak/floor trackers, braking and limit rules.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | sink      | in_valid/in_stall  | velocity_in
//   out     | source    | out_valid/out_stall| velocity_out, median_out, brake_stop
//   cfg     | sink      | cfg_we             | cfg_index, cfg_data
//
// An item is taken in the idle state, then passes the rank unit (one candidate
// per cycle) and the tracker update, selection, braking and guard steps; no new
// item is taken until the guard step hands its result over.
// The result sits in an output register; the next item is accepted while it
// waits, and the guard step holds until that register is free.
// Reset loads every register at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "median_peak_hold_velocity_filter_core_macros.svh"

module median_peak_hold_velocity_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mphvf_pkg::VAL_W-1:0]  velocity_in,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mphvf_pkg::VAL_W-1:0]  velocity_out,
	output logic signed [mphvf_pkg::VAL_W-1:0]  median_out,
	output logic                                brake_stop,
	// configuration
	input  logic                                cfg_we,
	input  logic [mphvf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mphvf_pkg::BAND_W-1:0]        cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RANK   = 3'd1;
	localparam logic [2:0] ST_TRACK  = 3'd2;
	localparam logic [2:0] ST_SELECT = 3'd3;
	localparam logic [2:0] ST_BRAKE  = 3'd4;
	localparam logic [2:0] ST_GUARD  = 3'd5;

	logic [2:0] state_q;

	// configuration registers
	mphvf_pkg::band_t             slope_band_q;
	mphvf_pkg::band_t             speed_db_q;
	mphvf_pkg::band_t             accel_db_q;
	mphvf_pkg::band_t             brake_jump_q;
	mphvf_pkg::band_t             speed_limit_q;
	logic [mphvf_pkg::HOLD_W-1:0] hold_period_q;

	// filter state
	mphvf_pkg::sample_t           win_q [mphvf_pkg::WINDOW_LEN];
	logic [mphvf_pkg::HOLD_W-1:0] hold_q;
	mphvf_pkg::sample_t           pos_peak_q;
	mphvf_pkg::sample_t           pos_floor_q;
	mphvf_pkg::sample_t           neg_peak_q;
	mphvf_pkg::sample_t           neg_floor_q;
	mphvf_pkg::sample_t           held_q;
	mphvf_pkg::sample_t           last_q;
	mphvf_pkg::sample_t           prior_q;

	// per-item working registers
	mphvf_pkg::sample_t           v_q;
	mphvf_pkg::sample_t           med_q;
	logic                         med_found_q;
	logic [mphvf_pkg::IDX_W-1:0]  cand_q;
	mphvf_pkg::sample_t           y_q;
	logic                         brake_q;

	// output register
	logic                         out_valid_q;
	mphvf_pkg::sample_t           vel_out_q;
	mphvf_pkg::sample_t           med_out_q;
	logic                         brake_out_q;

	logic in_take;
	logic out_take;
	logic last_cand;
	logic rank_hit;
	logic guard_go;
	logic [mphvf_pkg::HOLD_W:0] hold_next;
	logic hold_clear;

	// tracker step
	mphvf_pkg::wide_t d_med;
	mphvf_pkg::wide_t sb_w;
	logic med_pos;
	logic med_neg;

	// selection step
	mphvf_pkg::wide_t d_v;
	mphvf_pkg::wide_t v_w;
	mphvf_pkg::wide_t sd_w;
	mphvf_pkg::wide_t ad_w;
	logic v_fast_pos;
	logic v_fast_neg;

	// braking step
	mphvf_pkg::wide_t d_y;
	mphvf_pkg::wide_t bj_w;

	// guard step
	logic               reversal;
	mphvf_pkg::sample_t y_rev;
	mphvf_pkg::sample_t y_fin;

	assign in_stall     = (state_q != ST_IDLE);
	assign in_take      = in_valid && !in_stall;
	assign out_take     = out_valid_q && !out_stall;
	assign last_cand    = (cand_q == mphvf_pkg::IDX_W'(mphvf_pkg::WINDOW_LEN - 1));
	assign guard_go     = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign velocity_out = vel_out_q;
	assign median_out   = med_out_q;
	assign brake_stop   = brake_out_q;

	// shared rank unit
	mphvf_rank u_rank (
		.window (win_q),
		.cand   (cand_q),
		.hit    (rank_hit)
	);

	// hold counter test, nine bits so the top count still wraps to a clear
	assign hold_next  = {1'b0, hold_q} + (mphvf_pkg::HOLD_W + 1)'(1);
	assign hold_clear = hold_next > {1'b0, hold_period_q};

	// step arithmetic
	always_comb begin
		d_med      = mphvf_pkg::widen(med_q) - mphvf_pkg::widen(last_q);
		sb_w       = mphvf_pkg::band_wide(slope_band_q);
		med_pos    = med_q > 0;
		med_neg    = med_q < 0;

		v_w        = mphvf_pkg::widen(v_q);
		d_v        = v_w - mphvf_pkg::widen(last_q);
		sd_w       = mphvf_pkg::band_wide(speed_db_q);
		ad_w       = mphvf_pkg::band_wide(accel_db_q);
		v_fast_pos = v_w > sd_w;
		v_fast_neg = v_w < -sd_w;

		d_y        = mphvf_pkg::widen(y_q) - mphvf_pkg::widen(prior_q);
		bj_w       = mphvf_pkg::band_wide(brake_jump_q);

		reversal   = (last_q != 0) && (((last_q > 0) && (y_q < 0)) ||
		                               ((last_q < 0) && (y_q > 0)));
		y_rev      = reversal ? last_q : y_q;
		y_fin      = (mphvf_pkg::magnitude(y_rev) > mphvf_pkg::mag_t'(speed_limit_q)) ?
		             last_q : y_rev;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_band_q  <= mphvf_pkg::SLOPE_BAND_RST;
			speed_db_q    <= mphvf_pkg::SPEED_DB_RST;
			accel_db_q    <= mphvf_pkg::ACCEL_DB_RST;
			brake_jump_q  <= mphvf_pkg::BRAKE_JUMP_RST;
			speed_limit_q <= mphvf_pkg::SPEED_LIMIT_RST;
			hold_period_q <= mphvf_pkg::HOLD_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mphvf_pkg::REG_SLOPE_BAND:  slope_band_q  <= cfg_data;
				mphvf_pkg::REG_SPEED_DB:    speed_db_q    <= cfg_data;
				mphvf_pkg::REG_ACCEL_DB:    accel_db_q    <= cfg_data;
				mphvf_pkg::REG_BRAKE_JUMP:  brake_jump_q  <= cfg_data;
				mphvf_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				mphvf_pkg::REG_HOLD_PERIOD: hold_period_q <= cfg_data[mphvf_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < mphvf_pkg::WINDOW_LEN; i++)
				win_q[i] <= '0;
			hold_q      <= '0;
			pos_peak_q  <= '0;
			pos_floor_q <= mphvf_pkg::POS_FLOOR_RST;
			neg_peak_q  <= '0;
			neg_floor_q <= mphvf_pkg::NEG_FLOOR_RST;
			held_q      <= '0;
			last_q      <= '0;
			prior_q     <= '0;
			v_q         <= '0;
			med_q       <= '0;
			med_found_q <= 1'b0;
			cand_q      <= '0;
			y_q         <= '0;
			brake_q     <= 1'b0;
			out_valid_q <= 1'b0;
			vel_out_q   <= '0;
			med_out_q   <= '0;
			brake_out_q <= 1'b0;
		end else begin
			// a result taken in the cycle the guard loads a new one stays valid
			if (out_take && !((state_q == ST_GUARD) && guard_go))
				out_valid_q <= 1'b0;

			case (state_q)
				// take a sample, run the hold counter, shift the window
				ST_IDLE: begin
					if (in_take) begin
						v_q         <= velocity_in;
						cand_q      <= '0;
						med_found_q <= 1'b0;
						for (int i = 0; i < mphvf_pkg::WINDOW_LEN - 1; i++)
							win_q[i] <= win_q[i + 1];
						win_q[mphvf_pkg::WINDOW_LEN - 1] <= velocity_in;
						if (hold_clear) begin
							hold_q      <= '0;
							pos_peak_q  <= '0;
							pos_floor_q <= mphvf_pkg::POS_FLOOR_RST;
							neg_peak_q  <= '0;
							neg_floor_q <= mphvf_pkg::NEG_FLOOR_RST;
							held_q      <= '0;
							prior_q     <= '0;
						end else begin
							hold_q <= hold_next[mphvf_pkg::HOLD_W-1:0];
						end
						state_q <= ST_RANK;
					end
				end

				// one candidate per cycle through the rank unit
				ST_RANK: begin
					if (rank_hit && !med_found_q) begin
						med_q       <= mphvf_pkg::trunc_whole(win_q[cand_q]);
						med_found_q <= 1'b1;
					end
					if (last_cand)
						state_q <= ST_TRACK;
					else
						cand_q <= cand_q + mphvf_pkg::IDX_W'(1);
				end

				// peak and floor trackers
				ST_TRACK: begin
					if (med_pos && (d_med > -sb_w) && (med_q > pos_peak_q))
						pos_peak_q <= med_q;
					if (med_pos && (d_med < sb_w) && (med_q < pos_floor_q))
						pos_floor_q <= med_q;
					if (med_neg && (d_med < sb_w) && (med_q < neg_peak_q))
						neg_peak_q <= med_q;
					if (med_neg && (d_med > -sb_w) && (med_q > neg_floor_q))
						neg_floor_q <= med_q;
					state_q <= ST_SELECT;
				end

				// pick a tracker by speed and acceleration band
				ST_SELECT: begin
					if (v_fast_pos && (d_v > -ad_w)) begin
						y_q    <= pos_peak_q;
						held_q <= pos_peak_q;
					end else if (v_fast_pos && (d_v < ad_w)) begin
						y_q <= pos_floor_q;
					end else if (v_fast_neg && (d_v < ad_w)) begin
						y_q    <= neg_peak_q;
						held_q <= neg_peak_q;
					end else if (v_fast_neg && (d_v > -ad_w)) begin
						y_q <= neg_floor_q;
					end else begin
						y_q <= held_q;
					end
					state_q <= ST_BRAKE;
				end

				// braking jump against the output two back
				ST_BRAKE: begin
					if (((d_y < -bj_w) && (y_q > 0)) || ((d_y > bj_w) && (y_q < 0))) begin
						y_q     <= '0;
						brake_q <= 1'b1;
					end else begin
						brake_q <= 1'b0;
					end
					state_q <= ST_GUARD;
				end

				// reversal and limit guards, then hand over to the output register
				ST_GUARD: begin
					if (guard_go) begin
						vel_out_q   <= y_fin;
						med_out_q   <= med_q;
						brake_out_q <= brake_q;
						out_valid_q <= 1'b1;
						prior_q     <= last_q;
						last_q      <= y_fin;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`MPHVF_ASSERT_NEXT(a_accept_starts_rank, in_valid && !in_stall, state_q == ST_RANK, "accepted sample did not start the rank pass")
	`MPHVF_ASSERT_NEXT(a_median_found, (state_q == ST_RANK) && last_cand, med_found_q, "rank pass ended without a median")
	`MPHVF_ASSERT(a_brake_zero, out_valid && brake_stop |-> velocity_out == '0, "braked output is not zero")
	`MPHVF_ASSERT(a_median_whole, out_valid |-> median_out[mphvf_pkg::FRAC_BITS-1:0] == '0, "median has fraction bits")

endmodule

FILE: design/mphvf_rank.sv
// ----------------------------------------------------------------------------
// mphvf_rank
// Rank test of one window candidate against every window entry.
// ----------------------------------------------------------------------------
module mphvf_rank (
	input  mphvf_pkg::sample_t           window [mphvf_pkg::WINDOW_LEN],
	input  logic [mphvf_pkg::IDX_W-1:0]  cand,
	output logic                         hit
);

	// Count entries ranked ahead of and equal to the candidate
	always_comb begin
		logic [mphvf_pkg::CNT_W-1:0] less;
		logic [mphvf_pkg::CNT_W-1:0] same;
		logic [mphvf_pkg::CNT_W:0]   upto;
		mphvf_pkg::sample_t          c;
		c    = window[cand];
		less = '0;
		same = '0;
		for (int j = 0; j < mphvf_pkg::WINDOW_LEN; j++) begin
			if (mphvf_pkg::ranks_before(window[j], c))
				less = less + mphvf_pkg::CNT_W'(1);
			if (window[j] == c)
				same = same + mphvf_pkg::CNT_W'(1);
		end
		upto = {1'b0, less} + {1'b0, same};
		// candidate's value class covers the median rank
		hit  = (less <= mphvf_pkg::CNT_W'(mphvf_pkg::MEDIAN_RANK)) &&
		       (upto > (mphvf_pkg::CNT_W + 1)'(mphvf_pkg::MEDIAN_RANK));
	end

endmodule
